[hw/rtl/nearest_path_point_search_assert.svh]
// assertion macros for the nearest path point search block
`ifndef NEAREST_PATH_POINT_SEARCH_ASSERT_SVH
`define NEAREST_PATH_POINT_SEARCH_ASSERT_SVH

// property holds at every clock edge outside reset
`define NPPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never occurs outside reset
`define NPPS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/npps_pkg.sv]
// shared types and constants for the nearest path point search block
package npps_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned CoordW    = 24;
  localparam int unsigned HeadW     = 16;
  localparam int unsigned DistW     = 51;
  localparam int unsigned EntryW    = 2 * CoordW + HeadW;
  localparam int unsigned AbsW      = CoordW + 1;
  localparam int unsigned SqW       = 2 * AbsW;

  localparam logic [DistW-1:0] LimitReset      = DistW'(14745600);
  localparam logic [HeadW-1:0] QuarterTurn     = HeadW'(16384);
  localparam logic [HeadW-1:0] NegQuarterTurn  = HeadW'(49152);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOFIT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

[hw/rtl/npps_ctrl.sv]
// controller state machine for the nearest path point search block
module npps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        opcode_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  npps_pkg::dp_stat_t  stat_i,
  output npps_pkg::ctrl_cmd_t cmd_o
);
  import npps_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OP_QUERY && !stat_i.count_zero) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

`include "nearest_path_point_search_assert.svh"

  `NPPS_ASSERT_NEVER(a_busy_accept, state_q != S_IDLE && s_ready_o, "item taken while busy")
  `NPPS_ASSERT(a_scan_holds, state_q == S_SCAN && !stat_i.scan_last |=> state_q == S_SCAN, "scan cut short")
  `NPPS_ASSERT_NEVER(a_scan_empty, state_q == S_SCAN && stat_i.count_zero, "scan of empty table")

endmodule

[hw/rtl/npps_dpath.sv]
// table storage, distance pipeline and result registers for the path point search
module npps_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  npps_pkg::ctrl_cmd_t          cmd_i,
  output npps_pkg::dp_stat_t           stat_o,
  input  logic [1:0]                   opcode_i,
  input  logic signed [npps_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [npps_pkg::CoordW-1:0] pos_y_i,
  input  logic [npps_pkg::HeadW-1:0]   heading_i,
  input  logic                         cfg_we_i,
  input  logic [npps_pkg::DistW-1:0]   cfg_wdata_i,
  output logic [1:0]                   status_o,
  output logic [npps_pkg::IdxW-1:0]    index_o,
  output logic [npps_pkg::DistW-1:0]   dist_o
);
  import npps_pkg::*;

  logic [EntryW-1:0] point_mem [MaxPoints];

  logic [DistW-1:0]         limit_q;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          scan_cnt_q;
  logic                     full;

  logic [1:0]               op_q;
  logic signed [CoordW-1:0] qx_q, qy_q;
  logic [HeadW-1:0]         qh_q;
  logic [1:0]               res_status_q;
  logic [IdxW-1:0]          res_idx_q;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [EntryW-1:0]        rd_q;
  logic [IdxW-1:0]          idx1_q, idx2_q, idx3_q, idx4_q;
  logic [AbsW-1:0]          absx2_q, absy2_q;
  logic [SqW-1:0]           sqx3_q, sqy3_q;
  logic [DistW-1:0]         d2_4_q;

  logic                     found_q;
  logic [DistW-1:0]         best_q;
  logic [IdxW-1:0]          best_i_q;

  logic [1:0]               out_status_q;
  logic [IdxW-1:0]          out_idx_q;
  logic [DistW-1:0]         out_dist_q;

  logic signed [CoordW-1:0] rx, ry;
  logic [HeadW-1:0]         rh, hd;
  logic                     hok;
  logic signed [AbsW-1:0]   dx, dy;
  logic [1:0]               fin_status;
  logic [IdxW-1:0]          fin_idx;
  logic [DistW-1:0]         fin_dist;

  assign full = (count_q == CntW'(MaxPoints));

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.scan_last  = (scan_cnt_q == count_q - CntW'(1));
  assign stat_o.pipe_busy  = v1_q || v2_q || v3_q || v4_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && opcode_i == OP_APPEND && !full) begin
      point_mem[count_q[IdxW-1:0]] <= {heading_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.issue) begin
      rd_q <= point_mem[scan_cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LimitReset;
      count_q    <= '0;
      scan_cnt_q <= '0;
      found_q    <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
        if (opcode_i == OP_CLEAR) begin
          count_q <= '0;
        end else if (opcode_i == OP_APPEND && !full) begin
          count_q <= count_q + CntW'(1);
        end
      end else if (cmd_i.issue) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q && hok;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (v4_q && (!found_q || d2_4_q < best_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  // query point and non-query result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q         <= opcode_i;
      qx_q         <= pos_x_i;
      qy_q         <= pos_y_i;
      qh_q         <= heading_i;
      res_status_q <= STAT_OK;
      res_idx_q    <= '0;
      unique case (opcode_i)
        OP_APPEND: begin
          if (full) begin
            res_status_q <= STAT_FULL;
          end else begin
            res_idx_q <= count_q[IdxW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign rx = rd_q[CoordW-1:0];
  assign ry = rd_q[2*CoordW-1:CoordW];
  assign rh = rd_q[EntryW-1:2*CoordW];
  assign hd = rh - qh_q;
  assign hok = (hd <= QuarterTurn) || (hd >= NegQuarterTurn);
  assign dx = AbsW'(rx) - AbsW'(qx_q);
  assign dy = AbsW'(ry) - AbsW'(qy_q);

  // distance pipeline and running minimum
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      idx1_q <= scan_cnt_q[IdxW-1:0];
    end
    absx2_q <= dx[AbsW-1] ? AbsW'(-dx) : AbsW'(dx);
    absy2_q <= dy[AbsW-1] ? AbsW'(-dy) : AbsW'(dy);
    idx2_q  <= idx1_q;
    sqx3_q  <= absx2_q * absx2_q;
    sqy3_q  <= absy2_q * absy2_q;
    idx3_q  <= idx2_q;
    d2_4_q  <= DistW'(sqx3_q) + DistW'(sqy3_q);
    idx4_q  <= idx3_q;
    if (v4_q && (!found_q || d2_4_q < best_q)) begin
      best_q   <= d2_4_q;
      best_i_q <= idx4_q;
    end
  end

  always_comb begin
    fin_status = res_status_q;
    fin_idx    = res_idx_q;
    fin_dist   = '0;
    if (op_q == OP_QUERY) begin
      if (!found_q) begin
        fin_status = STAT_NOFIT;
        fin_idx    = '0;
        fin_dist   = '1;
      end else if (best_q > limit_q) begin
        fin_status = STAT_NOFIT;
        fin_idx    = '0;
        fin_dist   = best_q;
      end else begin
        fin_status = STAT_OK;
        fin_idx    = best_i_q;
        fin_dist   = best_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= fin_status;
      out_idx_q    <= fin_idx;
      out_dist_q   <= fin_dist;
    end
  end

  assign status_o = out_status_q;
  assign index_o  = out_idx_q;
  assign dist_o   = out_dist_q;

`include "nearest_path_point_search_assert.svh"

  `NPPS_ASSERT_NEVER(a_count_range, count_q > CntW'(MaxPoints), "point count beyond table")
  `NPPS_ASSERT_NEVER(a_issue_range, cmd_i.issue && scan_cnt_q >= count_q, "read past last point")
  `NPPS_ASSERT(a_found_after_hit, v4_q && !cmd_i.accept |=> found_q, "candidate not recorded")

endmodule

[hw/rtl/nearest_path_point_search.sv]
// top level of the nearest path point search block
//
// input stream: s_axis_tuser carries the opcode (clear, append, query), s_axis_tdata
// the point x, y and heading. every item gives exactly one result item on the
// output stream: status in m_axis_tuser, index and squared distance in m_axis_tdata.
// cfg_we_i loads the squared distance limit from cfg_wdata_i; write only while idle.
// clear and append: the result goes to the output register, and the next item is not
// taken until the block has loaded it and is back in idle.
// query over n stored points: one table read per cycle from the single read port
// of the memory feeds a four-stage distance pipeline.
// the table holds up to 4096 points; an append to a full table is dropped with a
// full status. reset empties the table and restores the default limit, no
// clearing pass is needed.
// a stalled receiver holds the result in the output register; the block still
// takes one more item and finishes it, then waits before showing its result.
module nearest_path_point_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], heading[63:48]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // nearest_index[11:0], min_distance_squared[62:12], zero
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_we_i,
  input  logic [50:0] cfg_wdata_i
);
  import npps_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [1:0]       status;
  logic [IdxW-1:0]  index;
  logic [DistW-1:0] min_dist;

  npps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .opcode_i  (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  npps_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (s_axis_tuser),
    .pos_x_i     (s_axis_tdata[23:0]),
    .pos_y_i     (s_axis_tdata[47:24]),
    .heading_i   (s_axis_tdata[63:48]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .index_o     (index),
    .dist_o      (min_dist)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {1'b0, min_dist, index};

endmodule

[verif/tb_top.sv]
// self-checking testbench for the nearest path point search block
`timescale 1ns / 100ps

module tb_top;
  import npps_pkg::*;

  localparam int                 WatchdogLimit = 20000;
  localparam int                 SettleCycles  = 8;
  localparam logic [1:0]         OpReserved    = 2'd3;
  localparam logic signed [23:0] MinCoord      = 24'h800000;
  localparam logic signed [23:0] MaxCoord      = 24'h7FFFFF;

  typedef struct {
    status_e     status;
    logic [11:0] index;
    logic [50:0] dist_sq;
  } answer_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // pos_x[23:0], pos_y[47:24], heading[63:48]
  logic [1:0]  s_axis_tuser  = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // nearest_index[11:0], min_distance_squared[62:12], zero
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        cfg_we_i      = 1'b0;
  logic [50:0] cfg_wdata_i   = '0;

  logic signed [23:0] path_x [MaxPoints];
  logic signed [23:0] path_y [MaxPoints];
  logic [15:0]        path_heading [MaxPoints];
  int                 path_count = 0;
  logic [50:0]        dist_limit = LimitReset;

  answer_t  pending_answers [$];
  answer_t  head_answer;
  int       errors       = 0;
  int       items_sent   = 0;
  int       burst_left   = 0;
  int       quiet_cycles = 0;
  int       mode_left    = 0;
  rx_mode_e rx_mode      = RX_ALWAYS;

  nearest_path_point_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic answer_t path_search_result(input logic [1:0] op,
      input logic signed [23:0] qx, input logic signed [23:0] qy, input logic [15:0] qh);
    answer_t     ans;
    logic [15:0] hdiff;
    longint      dx;
    longint      dy;
    logic [50:0] d2;
    logic [50:0] best;
    bit          found;
    int          best_i;
    ans    = '{status: STAT_OK, index: '0, dist_sq: '0};
    found  = 1'b0;
    best   = '0;
    best_i = 0;
    case (op)
      OP_CLEAR: path_count = 0;
      OP_APPEND: begin
        if (path_count >= MaxPoints) begin
          ans.status = STAT_FULL;
        end else begin
          path_x[path_count]       = qx;
          path_y[path_count]       = qy;
          path_heading[path_count] = qh;
          ans.index                = 12'(path_count);
          path_count++;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < path_count; i++) begin
          // more than a quarter turn off in either direction
          hdiff = path_heading[i] - qh;
          if (hdiff > QuarterTurn && hdiff < NegQuarterTurn) continue;
          dx = longint'(path_x[i]) - longint'(qx);
          dy = longint'(path_y[i]) - longint'(qy);
          d2 = 51'(dx * dx + dy * dy);
          if (!found || d2 < best) begin
            best   = d2;
            best_i = i;
            found  = 1'b1;
          end
        end
        if (!found) begin
          ans.status  = STAT_NOFIT;
          ans.dist_sq = '1;
        end else if (best > dist_limit) begin
          ans.status  = STAT_NOFIT;
          ans.dist_sq = best;
        end else begin
          ans.index   = 12'(best_i);
          ans.dist_sq = best;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [23:0] x,
      input logic signed [23:0] y, input logic [15:0] h);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {h, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_answers.insert(pending_answers.size(), path_search_result(op, x, y, h));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [50:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dist_limit  = value;
  endtask

  task automatic test_coordinate_extremes();
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_APPEND, MinCoord, MinCoord, 16'hFFFF);
    // opposite corners, heading wraps through zero
    send_item(OP_QUERY, MaxCoord, MaxCoord, 16'h0000);
    wait_drained();
    write_limit('1);
    send_item(OP_QUERY, MaxCoord, MaxCoord, 16'h0000);
    wait_drained();
    write_limit('0);
    send_item(OP_QUERY, MinCoord, MinCoord, 16'hFFFF);
    send_item(OP_QUERY, MinCoord + 24'sd1, MinCoord, 16'hFFFF);
    wait_drained();
    // exactly 15 m off is still within the limit
    write_limit(LimitReset);
    send_item(OP_QUERY, MinCoord + 24'sd3840, MinCoord, 16'hFFFF);
    send_item(OP_QUERY, MinCoord + 24'sd3841, MinCoord, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_empty_table();
    send_item(OP_CLEAR, MaxCoord, MinCoord, 16'hFFFF);
    send_item(OP_QUERY, '0, '0, '0);
    send_item(OpReserved, MaxCoord, MaxCoord, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_heading_window();
    logic [15:0] h0;
    h0 = 16'h1000;
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_APPEND, '0, '0, h0);
    send_item(OP_QUERY, '0, '0, h0 + QuarterTurn);
    send_item(OP_QUERY, '0, '0, h0 - QuarterTurn);
    send_item(OP_QUERY, '0, '0, h0 + QuarterTurn + 16'd1);
    send_item(OP_QUERY, '0, '0, h0 - QuarterTurn - 16'd1);
    send_item(OP_QUERY, '0, '0, h0 + 16'h8000);
    wait_drained();
  endtask

  task automatic test_tie_break();
    logic [15:0] h0;
    h0 = 16'h1000;
    send_item(OP_APPEND, 24'sd256, '0, h0);
    send_item(OP_APPEND, '0, 24'sd256, h0);
    send_item(OP_QUERY, 24'sd256, 24'sd256, h0);
    send_item(OP_QUERY, 24'sd128, 24'sd128, h0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [50:0]        limits [5];
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        ph;
    int                 cx;
    int                 cy;
    int                 hb;
    int                 n_pts;
    int                 n_qry;
    int                 phase_start;
    limits[0] = 51'($urandom_range(0, 32'h3FFF_FFFF));
    limits[1] = LimitReset;
    limits[2] = '1;
    limits[3] = '0;
    limits[4] = {19'($urandom), $urandom};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < 20) begin
        if ($urandom_range(0, 9) < 7) begin
          // a cluster of points around a random centre, then queries near it
          cx = int'($urandom_range(0, 16760832)) - 8380416;
          cy = int'($urandom_range(0, 16760832)) - 8380416;
          hb = int'($urandom_range(0, 65535));
          if ($urandom_range(0, 7) != 0) begin
            send_item(OP_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom));
          end
          n_pts = $urandom_range(1, 10);
          for (int k = 0; k < n_pts; k++) begin
            if (k == 0 || $urandom_range(0, 3) != 0) begin
              px = 24'(cx + int'($urandom_range(0, 8192)) - 4096);
              py = 24'(cy + int'($urandom_range(0, 8192)) - 4096);
              ph = 16'(hb + int'($urandom_range(0, 40000)) - 20000);
            end
            send_item(OP_APPEND, px, py, ph);
          end
          n_qry = $urandom_range(1, 4);
          for (int k = 0; k < n_qry; k++) begin
            send_item(OP_QUERY, 24'(cx + int'($urandom_range(0, 8192)) - 4096),
                      24'(cy + int'($urandom_range(0, 8192)) - 4096),
                      16'(hb + int'($urandom_range(0, 40000)) - 20000));
          end
        end else begin
          send_item(2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
                    16'($urandom));
        end
      end
      wait_drained();
    end
  endtask

  // receiver stalls in modes that are picked at random and changed when mode_left runs out
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(16, 96);
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:   m_axis_tready <= (mode_left % 8 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d index %0d dist %0d",
                 $time, m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[62:12]);
        errors++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (m_axis_tuser !== head_answer.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, head_answer.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[11:0] !== head_answer.index) begin
          $display("%0t: nearest index expected %0d actual %0d",
                   $time, head_answer.index, m_axis_tdata[11:0]);
          errors++;
        end
        if (m_axis_tdata[62:12] !== head_answer.dist_sq) begin
          $display("%0t: min distance squared expected %0d actual %0d",
                   $time, head_answer.dist_sq, m_axis_tdata[62:12]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_coordinate_extremes();
    test_empty_table();
    test_heading_window();
    test_tie_break();
    test_random_traffic();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
